// ===== sv/assert_macros.svh =====
// Assertion macros used by the checker file of the filter block.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Concurrent assertion on the rising clock edge, off while reset is low.
`define ASSERT_ON_CLK(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// Implication with the consequent in the cycle after the antecedent.
`define ASSERT_NEXT(lbl, pre, post, msg) \
  `ASSERT_ON_CLK(lbl, (pre) |=> (post), msg)

`endif

// ===== sv/icf_pkg.sv =====
// Package of the 3x3 filter: sizes, word types, register codes and kernel tables.
package icf_pkg;

  // Image limits and field widths
  localparam int MAX_WIDTH  = 1024;
  localparam int MAX_HEIGHT = 1024;
  localparam int PIX_W      = 8;
  localparam int VAL_W      = 13;
  localparam int DIM_W      = 11;
  localparam int COL_W      = $clog2(MAX_WIDTH);
  localparam int ROW_W      = $clog2(MAX_HEIGHT + 1) + 1;
  localparam int OIDX_W     = 20;
  localparam int TOT_W      = OIDX_W + 1;
  localparam int REM_W      = $clog2(MAX_WIDTH + 1);
  localparam int DIVC_W     = $clog2(OIDX_W);
  localparam int NUM_TAPS   = 9;
  localparam int COEF_W     = 4;

  // Register file
  localparam int ADDR_W     = 4;
  localparam int REG_IDX_W  = 2;
  localparam int DATA_W     = 32;
  localparam logic [REG_IDX_W-1:0] REG_KERNEL = 2'd0;
  localparam logic [REG_IDX_W-1:0] REG_WIDTH  = 2'd1;
  localparam logic [REG_IDX_W-1:0] REG_HEIGHT = 2'd2;

  localparam logic [DIM_W-1:0] RESET_WIDTH  = 11'd640;
  localparam logic [DIM_W-1:0] RESET_HEIGHT = 11'd480;
  localparam logic [TOT_W-1:0] RESET_TOTAL  = TOT_W'(640 * 480);

  typedef enum logic [1:0] {
    KERNEL_EMBOSS  = 2'd0,
    KERNEL_EDGE    = 2'd1,
    KERNEL_SHARPEN = 2'd2,
    KERNEL_BLUR    = 2'd3
  } kernel_e;

  typedef struct packed {
    logic [PIX_W-1:0] pixel;
    logic             is_flush;
  } in_word_t;

  typedef struct packed {
    logic signed [VAL_W-1:0] value;
    logic                    last;
  } out_word_t;

  // Effective configuration, dimensions already clamped
  typedef struct packed {
    kernel_e          kernel;
    logic [DIM_W-1:0] width;
    logic [DIM_W-1:0] height;
  } cfg_t;

  // Per-word control from the position tracker
  typedef struct packed {
    logic             step;
    logic             emit;
    logic             border;
    logic             last;
    logic [PIX_W-1:0] pix;
    logic [COL_W-1:0] col;
  } item_t;

  typedef logic signed [COEF_W-1:0] coef_t;
  typedef coef_t [0:NUM_TAPS-1] kernel_t;

  // Coefficients in row-major order, top row first
  function automatic kernel_t kernel_coefs(kernel_e sel);
    kernel_t k;
    unique case (sel)
      KERNEL_EMBOSS:  k = '{4'sd2, -4'sd1, 4'sd0, -4'sd1, 4'sd1, 4'sd1, 4'sd0, 4'sd1, 4'sd2};
      KERNEL_EDGE:    k = '{-4'sd1, 4'sd0, 4'sd1, -4'sd2, 4'sd0, 4'sd2, -4'sd1, 4'sd0, 4'sd1};
      KERNEL_SHARPEN: k = '{4'sd1, -4'sd2, 4'sd1, -4'sd2, 4'sd5, -4'sd2, 4'sd1, -4'sd2, 4'sd1};
      KERNEL_BLUR:    k = '{4'sd1, 4'sd1, 4'sd1, 4'sd1, 4'sd1, 4'sd1, 4'sd1, 4'sd1, 4'sd1};
      default:        k = '0;
    endcase
    return k;
  endfunction

  // Pixel times a small kernel coefficient, built from shifts
  function automatic logic signed [VAL_W-1:0] tap_term(logic [PIX_W-1:0] p, coef_t c);
    logic signed [VAL_W-1:0] pe;
    logic signed [VAL_W-1:0] r;
    pe = {{(VAL_W-PIX_W){1'b0}}, p};
    case (c)
      4'sd1:   r = pe;
      -4'sd1:  r = -pe;
      4'sd2:   r = pe <<< 1;
      -4'sd2:  r = -(pe <<< 1);
      4'sd5:   r = (pe <<< 2) + pe;
      default: r = '0;
    endcase
    return r;
  endfunction

endpackage

// ===== sv/icf_cfg_regs.sv =====
// APB register file: kernel select and image size, with clamped outputs.
module icf_cfg_regs (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         psel,
  input  logic                         penable,
  input  logic                         pwrite,
  input  logic [icf_pkg::ADDR_W-1:0]   paddr,
  input  logic [icf_pkg::DATA_W-1:0]   pwdata,
  output logic [icf_pkg::DATA_W-1:0]   prdata,
  output logic                         pready,
  output icf_pkg::cfg_t                cfg_o,
  output logic                         cfg_wr_o
);

  logic [icf_pkg::REG_IDX_W-1:0] idx;
  logic                          wr;
  icf_pkg::kernel_e              kernel_q;
  logic [icf_pkg::DIM_W-1:0]     width_q;
  logic [icf_pkg::DIM_W-1:0]     height_q;

  assign idx      = paddr[icf_pkg::ADDR_W-1:2];
  assign wr       = psel && penable && pwrite;
  assign pready   = 1'b1;
  assign cfg_wr_o = wr;

  // Write registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      kernel_q <= icf_pkg::KERNEL_EMBOSS;
      width_q  <= icf_pkg::RESET_WIDTH;
      height_q <= icf_pkg::RESET_HEIGHT;
    end else if (wr) begin
      unique case (idx)
        icf_pkg::REG_KERNEL: kernel_q <= icf_pkg::kernel_e'(pwdata[1:0]);
        icf_pkg::REG_WIDTH:  width_q  <= pwdata[icf_pkg::DIM_W-1:0];
        icf_pkg::REG_HEIGHT: height_q <= pwdata[icf_pkg::DIM_W-1:0];
        default: ;
      endcase
    end
  end

  // Read back
  always_comb begin
    unique case (idx)
      icf_pkg::REG_KERNEL: prdata = {{(icf_pkg::DATA_W-2){1'b0}}, kernel_q};
      icf_pkg::REG_WIDTH:  prdata = {{(icf_pkg::DATA_W-icf_pkg::DIM_W){1'b0}}, width_q};
      icf_pkg::REG_HEIGHT: prdata = {{(icf_pkg::DATA_W-icf_pkg::DIM_W){1'b0}}, height_q};
      default:             prdata = '0;
    endcase
  end

  // Clamp dimensions: zero becomes one, oversize saturates
  always_comb begin
    cfg_o.kernel = kernel_q;
    if (width_q == '0) begin
      cfg_o.width = icf_pkg::DIM_W'(1);
    end else if (width_q > icf_pkg::DIM_W'(icf_pkg::MAX_WIDTH)) begin
      cfg_o.width = icf_pkg::DIM_W'(icf_pkg::MAX_WIDTH);
    end else begin
      cfg_o.width = width_q;
    end
    if (height_q == '0) begin
      cfg_o.height = icf_pkg::DIM_W'(1);
    end else if (height_q > icf_pkg::DIM_W'(icf_pkg::MAX_HEIGHT)) begin
      cfg_o.height = icf_pkg::DIM_W'(icf_pkg::MAX_HEIGHT);
    end else begin
      cfg_o.height = height_q;
    end
  end

endmodule

// ===== sv/icf_pos_ctrl.sv =====
// Stream position tracking, border and end-of-image flags, and the row/column divider.
module icf_pos_ctrl (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  icf_pkg::cfg_t      cfg_i,
  input  logic               cfg_wr_i,
  input  logic               in_fire_i,
  input  icf_pkg::in_word_t  in_data_i,
  output logic               busy_o,
  output icf_pkg::item_t     item_o
);

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_LOAD = 2'd1;
  localparam logic [1:0] ST_DIV  = 2'd2;

  logic [1:0]                    state_q;
  logic [icf_pkg::ROW_W-1:0]     in_row_q;
  logic [icf_pkg::COL_W-1:0]     in_col_q;
  logic [icf_pkg::OIDX_W-1:0]    out_idx_q;
  logic [icf_pkg::OIDX_W-1:0]    orow_q;
  logic [icf_pkg::COL_W-1:0]     ocol_q;
  logic [icf_pkg::TOT_W-1:0]     total_q;
  logic [icf_pkg::REM_W-1:0]     rem_q;
  logic [icf_pkg::OIDX_W-1:0]    quo_q;
  logic [icf_pkg::DIVC_W-1:0]    cnt_q;

  logic [2*icf_pkg::DIM_W-1:0]   area;
  logic [icf_pkg::REM_W:0]       rem_sh;
  logic                          rem_ge;
  logic [icf_pkg::REM_W-1:0]     rem_d;
  logic [icf_pkg::OIDX_W-1:0]    quo_d;
  logic                          draining;
  logic                          ignore;
  logic                          step;
  logic                          emit;
  logic                          border;
  logic                          last;
  logic                          col_wrap;
  logic                          ocol_wrap;

  assign busy_o = (state_q != ST_IDLE);
  assign area   = cfg_i.width * cfg_i.height;

  // One restoring division step
  assign rem_sh = {rem_q, quo_q[icf_pkg::OIDX_W-1]};
  assign rem_ge = (rem_sh >= (icf_pkg::REM_W+1)'(cfg_i.width));
  assign rem_d  = rem_ge ? icf_pkg::REM_W'(rem_sh - (icf_pkg::REM_W+1)'(cfg_i.width))
                         : rem_sh[icf_pkg::REM_W-1:0];
  assign quo_d  = {quo_q[icf_pkg::OIDX_W-2:0], rem_ge};

  // Decode the current word against the stream position
  assign draining  = (in_row_q >= icf_pkg::ROW_W'(cfg_i.height));
  assign ignore    = in_data_i.is_flush && !draining;
  assign step      = in_fire_i && !ignore;
  assign emit      = (in_row_q >= icf_pkg::ROW_W'(2)) ||
                     ((in_row_q == icf_pkg::ROW_W'(1)) && (in_col_q != '0));
  assign col_wrap  = ((icf_pkg::DIM_W'(in_col_q) + 1'b1) >= cfg_i.width);
  assign ocol_wrap = ((icf_pkg::DIM_W'(ocol_q) + 1'b1) >= cfg_i.width);
  assign border    = (orow_q == '0) ||
                     ((icf_pkg::TOT_W'(orow_q) + 1'b1) >= icf_pkg::TOT_W'(cfg_i.height)) ||
                     (ocol_q == '0) || ocol_wrap;
  assign last      = ((icf_pkg::TOT_W'(out_idx_q) + 1'b1) >= total_q);

  always_comb begin
    item_o.step   = step;
    item_o.emit   = emit;
    item_o.border = border;
    item_o.last   = last;
    item_o.pix    = draining ? '0 : in_data_i.pixel;
    item_o.col    = in_col_q;
  end

  // Advance counters; recompute output row and column after a register write
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= ST_IDLE;
      in_row_q  <= '0;
      in_col_q  <= '0;
      out_idx_q <= '0;
      orow_q    <= '0;
      ocol_q    <= '0;
      total_q   <= icf_pkg::RESET_TOTAL;
      rem_q     <= '0;
      quo_q     <= '0;
      cnt_q     <= '0;
    end else if (cfg_wr_i) begin
      state_q <= ST_LOAD;
    end else begin
      unique case (state_q)
        ST_IDLE: begin
          if (step) begin
            if (emit && last) begin
              in_row_q  <= '0;
              in_col_q  <= '0;
              out_idx_q <= '0;
              orow_q    <= '0;
              ocol_q    <= '0;
            end else begin
              if (col_wrap) begin
                in_col_q <= '0;
                if (in_row_q != '1) begin
                  in_row_q <= in_row_q + 1'b1;
                end
              end else begin
                in_col_q <= in_col_q + 1'b1;
              end
              if (emit) begin
                out_idx_q <= out_idx_q + 1'b1;
                if (ocol_wrap) begin
                  ocol_q <= '0;
                  orow_q <= orow_q + 1'b1;
                end else begin
                  ocol_q <= ocol_q + 1'b1;
                end
              end
            end
          end
        end
        ST_LOAD: begin
          total_q <= area[icf_pkg::TOT_W-1:0];
          rem_q   <= '0;
          quo_q   <= out_idx_q;
          cnt_q   <= '0;
          state_q <= ST_DIV;
        end
        ST_DIV: begin
          rem_q <= rem_d;
          quo_q <= quo_d;
          cnt_q <= cnt_q + 1'b1;
          if (cnt_q == icf_pkg::DIVC_W'(icf_pkg::OIDX_W - 1)) begin
            orow_q  <= quo_d;
            ocol_q  <= rem_d[icf_pkg::COL_W-1:0];
            state_q <= ST_IDLE;
          end
        end
        default: state_q <= ST_IDLE;
      endcase
    end
  end

endmodule

// ===== sv/icf_line_store.sv =====
// Two row memories holding the previous two image rows, read-first with a delayed copy.
module icf_line_store (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        step_i,
  input  logic [icf_pkg::COL_W-1:0]   addr_i,
  input  logic [icf_pkg::PIX_W-1:0]   wdata_i,
  output logic [icf_pkg::PIX_W-1:0]   top_o,
  output logic [icf_pkg::PIX_W-1:0]   mid_o
);

  logic [icf_pkg::PIX_W-1:0] row0_mem [icf_pkg::MAX_WIDTH];
  logic [icf_pkg::PIX_W-1:0] row1_mem [icf_pkg::MAX_WIDTH];
  logic [icf_pkg::PIX_W-1:0] mid_q;
  logic [icf_pkg::PIX_W-1:0] top_q;
  logic                      pend_q;
  logic [icf_pkg::COL_W-1:0] pend_addr_q;

  assign top_o = top_q;
  assign mid_o = mid_q;

  // Newest row: write the pixel, read the old entry
  always_ff @(posedge clk_i) begin
    if (step_i) begin
      row0_mem[addr_i] <= wdata_i;
      mid_q            <= row0_mem[addr_i];
    end
  end

  // Older row: take the old newest-row entry in the following cycle; bypass a pending copy
  always_ff @(posedge clk_i) begin
    if (step_i) begin
      top_q <= (pend_q && (pend_addr_q == addr_i)) ? mid_q : row1_mem[addr_i];
    end
    if (pend_q) begin
      row1_mem[pend_addr_q] <= mid_q;
    end
  end

  // Track the pending copy
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pend_q      <= 1'b0;
      pend_addr_q <= '0;
    end else begin
      pend_q <= step_i;
      if (step_i) begin
        pend_addr_q <= addr_i;
      end
    end
  end

endmodule

// ===== sv/icf_window_mac.sv =====
// 3x3 window, kernel sum and output register.
module icf_window_mac (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  icf_pkg::item_t              item_i,
  input  logic [icf_pkg::PIX_W-1:0]   top_i,
  input  logic [icf_pkg::PIX_W-1:0]   mid_i,
  input  icf_pkg::kernel_e            kernel_i,
  input  logic                        out_ready_i,
  output logic                        out_valid_o,
  output icf_pkg::out_word_t          out_data_o,
  output logic                        free_o
);

  logic                          s1_valid_q;
  logic                          s1_emit_q;
  logic                          s1_border_q;
  logic                          s1_last_q;
  logic [icf_pkg::PIX_W-1:0]     s1_pix_q;
  logic [icf_pkg::PIX_W-1:0]     col0_q [3];
  logic [icf_pkg::PIX_W-1:0]     col1_q [3];
  logic                          out_valid_q;
  icf_pkg::out_word_t            out_q;

  logic                          adv;
  logic [icf_pkg::PIX_W-1:0]     taps [icf_pkg::NUM_TAPS];
  icf_pkg::kernel_t              coefs;
  logic signed [icf_pkg::VAL_W-1:0] sum;
  logic signed [icf_pkg::VAL_W-1:0] value_d;

  assign adv         = s1_valid_q && (!s1_emit_q || !out_valid_q || out_ready_i);
  assign free_o      = !s1_valid_q || adv;
  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  // Hold the accepted word while its line store reads come back
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q  <= 1'b0;
      s1_emit_q   <= 1'b0;
      s1_border_q <= 1'b0;
      s1_last_q   <= 1'b0;
      s1_pix_q    <= '0;
    end else if (item_i.step) begin
      s1_valid_q  <= 1'b1;
      s1_emit_q   <= item_i.emit;
      s1_border_q <= item_i.border;
      s1_last_q   <= item_i.last;
      s1_pix_q    <= item_i.pix;
    end else if (adv) begin
      s1_valid_q  <= 1'b0;
    end
  end

  // Shift the window left as each word leaves
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int r = 0; r < 3; r++) begin
        col0_q[r] <= '0;
        col1_q[r] <= '0;
      end
    end else if (adv) begin
      for (int r = 0; r < 3; r++) begin
        col0_q[r] <= col1_q[r];
      end
      col1_q[0] <= top_i;
      col1_q[1] <= mid_i;
      col1_q[2] <= s1_pix_q;
    end
  end

  // Gather taps row-major and sum them against the kernel
  always_comb begin
    taps[0] = col0_q[0];
    taps[1] = col1_q[0];
    taps[2] = top_i;
    taps[3] = col0_q[1];
    taps[4] = col1_q[1];
    taps[5] = mid_i;
    taps[6] = col0_q[2];
    taps[7] = col1_q[2];
    taps[8] = s1_pix_q;
  end

  assign coefs = icf_pkg::kernel_coefs(kernel_i);

  always_comb begin
    sum = '0;
    for (int t = 0; t < icf_pkg::NUM_TAPS; t++) begin
      sum = sum + icf_pkg::tap_term(taps[t], coefs[t]);
    end
  end

  // Border pixels pass the center tap through
  assign value_d = s1_border_q ? {{(icf_pkg::VAL_W-icf_pkg::PIX_W){1'b0}}, col1_q[1]} : sum;

  // Output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (adv && s1_emit_q) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv && s1_emit_q) begin
      out_q.value <= value_d;
      out_q.last  <= s1_last_q;
    end
  end

endmodule

// ===== sv/image_conv3x3_filter.sv =====
// Top level of the streaming 3x3 image filter.
// Takes one grey pixel per clock while ready is high, in raster order, and returns each
// pixel of the image, in raster order, filtered with the selected kernel (emboss, edge,
// sharpen or box blur) as a signed, unclamped 13-bit sum; border rows and columns pass
// through. A result appears width+1 words after its pixel, then passes the window stage
// and output registers once that word is taken; flush words push the last width+1
// results out once the whole image is in. The input rate rests on the two row memories,
// each handling one column per clock, read-first on the newest row. After any register
// write the input holds ready low while a serial divider rebuilds the output row and
// column from the output index, one quotient bit per clock. The row memories need no
// clearing after reset. Write registers only between words.
module image_conv3x3_filter (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         in_valid_i,
  output logic                         in_ready_o,
  input  icf_pkg::in_word_t            in_data_i,
  output logic                         out_valid_o,
  input  logic                         out_ready_i,
  output icf_pkg::out_word_t           out_data_o,
  input  logic                         psel,
  input  logic                         penable,
  input  logic                         pwrite,
  input  logic [icf_pkg::ADDR_W-1:0]   paddr,
  input  logic [icf_pkg::DATA_W-1:0]   pwdata,
  output logic [icf_pkg::DATA_W-1:0]   prdata,
  output logic                         pready
);

  icf_pkg::cfg_t             cfg;
  logic                      cfg_wr;
  logic                      busy;
  logic                      free;
  logic                      in_fire;
  icf_pkg::item_t            item;
  logic [icf_pkg::PIX_W-1:0] top;
  logic [icf_pkg::PIX_W-1:0] mid;

  // Accept a word when the window stage can move and no recompute runs
  assign in_ready_o = !busy && free;
  assign in_fire    = in_valid_i && in_ready_o;

  icf_cfg_regs u_cfg_regs (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .psel     (psel),
    .penable  (penable),
    .pwrite   (pwrite),
    .paddr    (paddr),
    .pwdata   (pwdata),
    .prdata   (prdata),
    .pready   (pready),
    .cfg_o    (cfg),
    .cfg_wr_o (cfg_wr)
  );

  icf_pos_ctrl u_pos_ctrl (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .cfg_i     (cfg),
    .cfg_wr_i  (cfg_wr),
    .in_fire_i (in_fire),
    .in_data_i (in_data_i),
    .busy_o    (busy),
    .item_o    (item)
  );

  icf_line_store u_line_store (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .step_i  (item.step),
    .addr_i  (item.col),
    .wdata_i (item.pix),
    .top_o   (top),
    .mid_o   (mid)
  );

  icf_window_mac u_window_mac (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .item_i      (item),
    .top_i       (top),
    .mid_i       (mid),
    .kernel_i    (cfg.kernel),
    .out_ready_i (out_ready_i),
    .out_valid_o (out_valid_o),
    .out_data_o  (out_data_o),
    .free_o      (free)
  );

endmodule

// ===== sv/icf_checker.sv =====
// Port-level checker for the 3x3 filter, bound to the top level.
`include "assert_macros.svh"

module icf_checker (
  input logic                         clk_i,
  input logic                         rst_ni,
  input logic                         in_valid_i,
  input logic                         in_ready_o,
  input icf_pkg::in_word_t            in_data_i,
  input logic                         out_valid_o,
  input logic                         out_ready_i,
  input icf_pkg::out_word_t           out_data_o,
  input logic                         psel,
  input logic                         penable,
  input logic                         pwrite,
  input logic [icf_pkg::ADDR_W-1:0]   paddr,
  input logic [icf_pkg::DATA_W-1:0]   pwdata,
  input logic [icf_pkg::DATA_W-1:0]   prdata,
  input logic                         pready
);

  logic cfg_write;
  logic unused_ok;

  assign cfg_write = psel && penable && pwrite && pready;
  assign unused_ok = in_valid_i ^ (^in_data_i);

  // A stalled result word holds
  `ASSERT_NEXT(a_out_hold, out_valid_o && !out_ready_i, out_valid_o && $stable(out_data_o), "result word changed while stalled")

  // A register write stalls the input for the position recompute
  `ASSERT_NEXT(a_busy_after_write, cfg_write, !in_ready_o ##1 !in_ready_o, "input ready during recompute")

  // The kernel register reads back what was written
  `ASSERT_ON_CLK(a_kernel_readback, (cfg_write && (paddr[3:2] == icf_pkg::REG_KERNEL)) ##1 (psel && !pwrite && (paddr[3:2] == icf_pkg::REG_KERNEL)) |-> (prdata[1:0] == $past(pwdata[1:0])), "kernel register readback mismatch")

endmodule

bind image_conv3x3_filter icf_checker u_icf_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (in_valid_i),
  .in_ready_o  (in_ready_o),
  .in_data_i   (in_data_i),
  .out_valid_o (out_valid_o),
  .out_ready_i (out_ready_i),
  .out_data_o  (out_data_o),
  .psel        (psel),
  .penable     (penable),
  .pwrite      (pwrite),
  .paddr       (paddr),
  .pwdata      (pwdata),
  .prdata      (prdata),
  .pready      (pready)
);

// ===== tb/image_conv3x3_filter_tb.sv =====
// Testbench of the 3x3 image filter: directed and random images checked against a predictor.
`timescale 1ns / 1ps

module image_conv3x3_filter_tb;
  import icf_pkg::*;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;

  logic in_valid_i = 1'b0;
  logic in_ready_o;
  in_word_t in_data_i = '0;
  logic out_valid_o;
  logic out_ready_i = 1'b0;
  out_word_t out_data_o;

  logic psel = 1'b0;
  logic penable = 1'b0;
  logic pwrite = 1'b0;
  logic [ADDR_W-1:0] paddr = '0;
  logic [DATA_W-1:0] pwdata = '0;
  logic [DATA_W-1:0] prdata;
  logic pready;

  // Predictor state: register copies, row memories, window and stream position
  kernel_e cfg_kernel = KERNEL_EMBOSS;
  logic [DIM_W-1:0] cfg_width = RESET_WIDTH;
  logic [DIM_W-1:0] cfg_height = RESET_HEIGHT;
  logic [PIX_W-1:0] row_mem [0:2*MAX_WIDTH-1];
  logic [PIX_W-1:0] win_px [0:8];
  int unsigned cur_row = 0;
  int unsigned cur_col = 0;
  int unsigned next_out = 0;
  bit image_done = 1'b0;

  out_word_t pending_pixels [$];
  out_word_t want;
  int unsigned fail_count = 0;
  int unsigned words_taken = 0;
  int in_gap_max = 10;
  int out_gap_max = 10;
  int hold_off_cycles = 0;
  bit took_result = 1'b0;

  image_conv3x3_filter u_top (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .in_data_i   (in_data_i),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_data_o  (out_data_o),
    .psel        (psel),
    .penable     (penable),
    .pwrite      (pwrite),
    .paddr       (paddr),
    .pwdata      (pwdata),
    .prdata      (prdata),
    .pready      (pready)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // Zero maps to one, anything past the limit saturates
  function automatic int unsigned clamp_dim(logic [DIM_W-1:0] v, int unsigned top);
    if (v == 0) return 1;
    if (v > top) return top;
    return v;
  endfunction

  // Kernel weights, row-major with the top row first
  function automatic int tap_weight(kernel_e k, int idx);
    int wgt;
    wgt = 0;
    case (k)
      KERNEL_EMBOSS: begin
        case (idx)
          0, 8: wgt = 2;
          1, 3: wgt = -1;
          4, 5, 7: wgt = 1;
          default: wgt = 0;
        endcase
      end
      KERNEL_EDGE: begin
        case (idx)
          0, 6: wgt = -1;
          2, 8: wgt = 1;
          3: wgt = -2;
          5: wgt = 2;
          default: wgt = 0;
        endcase
      end
      KERNEL_SHARPEN: begin
        case (idx)
          4: wgt = 5;
          1, 3, 5, 7: wgt = -2;
          default: wgt = 1;
        endcase
      end
      default: wgt = 1;
    endcase
    return wgt;
  endfunction

  // Advance the predicted image by one word; returns 0 when the word is dropped
  function automatic bit filter_word(in_word_t w);
    int unsigned wd, ht, col, orow, ocol;
    logic [PIX_W-1:0] pix;
    bit drain, emit;
    int acc, r, k;
    out_word_t res;
    wd = clamp_dim(cfg_width, MAX_WIDTH);
    ht = clamp_dim(cfg_height, MAX_HEIGHT);
    drain = (cur_row >= ht);
    // drop a flush while the image is still coming in
    if (w.is_flush && !drain) return 1'b0;
    pix = drain ? '0 : w.pixel;
    col = (cur_col >= MAX_WIDTH) ? MAX_WIDTH - 1 : cur_col;

    // shift the window left and pull in the new column
    for (r = 0; r < 3; r++) begin
      win_px[3*r] = win_px[3*r+1];
      win_px[3*r+1] = win_px[3*r+2];
    end
    win_px[2] = row_mem[MAX_WIDTH + col];
    win_px[5] = row_mem[col];
    win_px[8] = pix;
    row_mem[MAX_WIDTH + col] = row_mem[col];
    row_mem[col] = pix;

    emit = (cur_row >= 2) || (cur_row == 1 && cur_col >= 1);
    if (cur_col + 1 >= wd) begin
      cur_col = 0;
      cur_row++;
    end else begin
      cur_col++;
    end

    if (emit) begin
      orow = next_out / wd;
      ocol = next_out % wd;
      if (orow == 0 || orow + 1 >= ht || ocol == 0 || ocol + 1 >= wd) begin
        acc = int'(win_px[4]);
      end else begin
        acc = 0;
        for (k = 0; k < 9; k++) acc += int'(win_px[k]) * tap_weight(cfg_kernel, k);
      end
      res.value = acc[VAL_W-1:0];
      res.last = (next_out + 1 >= wd * ht);
      pending_pixels.push_back(res);
      if (res.last) begin
        cur_row = 0;
        cur_col = 0;
        next_out = 0;
        image_done = 1'b1;
      end else begin
        next_out = (next_out + 1) & 32'h000F_FFFF;
      end
    end
    return 1'b1;
  endfunction

  // Write one register through a setup and an access phase
  task automatic write_reg(logic [REG_IDX_W-1:0] idx, logic [DATA_W-1:0] data);
    psel = 1'b1;
    penable = 1'b0;
    pwrite = 1'b1;
    paddr = ADDR_W'({idx, 2'b00});
    pwdata = data;
    @(negedge clk_i);
    penable = 1'b1;
    do @(posedge clk_i); while (!pready);
    case (idx)
      REG_KERNEL: cfg_kernel = kernel_e'(data[1:0]);
      REG_WIDTH:  cfg_width = data[DIM_W-1:0];
      REG_HEIGHT: cfg_height = data[DIM_W-1:0];
      default: ;
    endcase
    @(negedge clk_i);
    psel = 1'b0;
    penable = 1'b0;
    pwrite = 1'b0;
  endtask

  // Offer one word after a random gap and hold it until taken
  task automatic send_word(logic [PIX_W-1:0] pix, logic flush);
    int gap;
    gap = $urandom_range(0, in_gap_max);
    if (gap > 0) begin
      in_valid_i = 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    in_data_i.pixel = pix;
    in_data_i.is_flush = flush;
    in_valid_i = 1'b1;
    do @(posedge clk_i); while (!in_ready_o);
    if (filter_word(in_data_i)) words_taken++;
    @(negedge clk_i);
    in_valid_i = 1'b0;
  endtask

  task automatic send_pixels(int n);
    repeat (n) send_word($urandom_range(0, 255), 1'b0);
  endtask

  // Feed the rest of the current image, then drain it until the word that yields the last pixel is taken
  task automatic finish_image(int noise_pct, int flush_pct);
    while (!image_done) begin
      if (cur_row < clamp_dim(cfg_height, MAX_HEIGHT)) begin
        if ($urandom_range(0, 99) < noise_pct) send_word($urandom_range(0, 255), 1'b1);
        send_word($urandom_range(0, 255), 1'b0);
      end else begin
        send_word($urandom_range(0, 255), $urandom_range(0, 99) < flush_pct);
      end
    end
    image_done = 1'b0;
  endtask

  // Wait for every predicted pixel, then let the pipeline settle
  task automatic wait_idle();
    while (pending_pixels.size() != 0) @(negedge clk_i);
    repeat (4) @(negedge clk_i);
  endtask

  task automatic set_size(int unsigned wd, int unsigned ht);
    write_reg(REG_WIDTH, wd);
    write_reg(REG_HEIGHT, ht);
  endtask

  // Sharpen on a cross of white over black: most negative sum, early flush dropped
  task automatic test_sharpen_minimum();
    int i;
    write_reg(REG_KERNEL, KERNEL_SHARPEN);
    set_size(3, 3);
    send_word(8'd255, 1'b1);
    for (i = 0; i < 9; i++) send_word((i % 2) ? 8'd255 : 8'd0, 1'b0);
    finish_image(0, 100);
  endtask

  // Box blur on all white: largest sum, drained with pixel words
  task automatic test_blur_maximum();
    wait_idle();
    write_reg(REG_KERNEL, KERNEL_BLUR);
    repeat (9) send_word(8'd255, 1'b0);
    finish_image(0, 0);
  endtask

  // Change registers part way through an image
  task automatic test_mid_image_changes();
    wait_idle();
    write_reg(REG_KERNEL, KERNEL_EDGE);
    set_size(9, 7);
    send_pixels(33);
    wait_idle();
    // narrow the image and switch kernel; the current column wraps
    write_reg(REG_KERNEL, KERNEL_EMBOSS);
    write_reg(REG_WIDTH, 4);
    finish_image(0, 75);
    wait_idle();
    write_reg(REG_KERNEL, KERNEL_BLUR);
    set_size(4, 8);
    send_pixels(20);
    wait_idle();
    // drop the height below the current row: the image ends on the next result
    write_reg(REG_HEIGHT, 3);
    finish_image(0, 100);
  endtask

  // Zero and saturated dimensions
  task automatic test_size_limits();
    in_gap_max = 2;
    out_gap_max = 2;
    wait_idle();
    set_size(1, 1);
    finish_image(0, 50);
    wait_idle();
    write_reg(REG_KERNEL, KERNEL_SHARPEN);
    set_size(0, 0);
    finish_image(0, 50);
    wait_idle();
    set_size(2047, 1);
    finish_image(0, 75);
    wait_idle();
    set_size(0, 2047);
    finish_image(0, 75);
  endtask

  // Stall the sink long enough to fill the block, then pause the source mid-image
  task automatic test_backpressure();
    in_gap_max = 0;
    out_gap_max = 3;
    wait_idle();
    write_reg(REG_KERNEL, KERNEL_BLUR);
    set_size(16, 10);
    hold_off_cycles = 300;
    send_pixels(96);
    wait_idle();
    finish_image(0, 100);
  endtask

  // Random kernels, sizes, content and idling, one image at a time
  task automatic test_random_images();
    int unsigned start_count, wd, ht;
    start_count = words_taken;
    while (words_taken - start_count < 1750) begin
      case ($urandom_range(0, 4))
        0: begin
          in_gap_max = 0;
          out_gap_max = 0;
        end
        1: begin
          in_gap_max = 0;
          out_gap_max = 10;
        end
        2: begin
          in_gap_max = 10;
          out_gap_max = 0;
        end
        default: begin
          in_gap_max = 10;
          out_gap_max = 10;
        end
      endcase
      wd = ($urandom_range(0, 7) == 0) ? $urandom_range(0, 24) : $urandom_range(1, 10);
      ht = ($urandom_range(0, 7) == 0) ? $urandom_range(0, 16) : $urandom_range(1, 10);
      wait_idle();
      write_reg(REG_KERNEL, $urandom_range(0, 3));
      set_size(wd, ht);
      finish_image(5, 75);
    end
  endtask

  // Sink: random gap after each result, long hold-off on request
  initial begin : result_sink
    int wait_left;
    wait_left = 0;
    forever begin
      @(negedge clk_i);
      if (took_result) begin
        wait_left = $urandom_range(0, out_gap_max);
        took_result = 1'b0;
      end
      if (hold_off_cycles > 0) begin
        wait_left = hold_off_cycles;
        hold_off_cycles = 0;
      end
      if (wait_left > 0) begin
        out_ready_i = 1'b0;
        wait_left--;
      end else begin
        out_ready_i = 1'b1;
      end
    end
  end

  // Compare each taken word with the oldest predicted pixel
  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && out_ready_i) begin
      took_result = 1'b1;
      if (pending_pixels.size() == 0) begin
        if (fail_count < 20)
          $display("%0t: unexpected word, expected none, got value %0d last %0b",
                   $time, out_data_o.value, out_data_o.last);
        fail_count++;
      end else begin
        want = pending_pixels.pop_front();
        if (out_data_o.value !== want.value || out_data_o.last !== want.last) begin
          if (fail_count < 20)
            $display("%0t: mismatch, expected value %0d last %0b, got value %0d last %0b",
                     $time, want.value, want.last, out_data_o.value, out_data_o.last);
          fail_count++;
        end
      end
    end
  end

  initial begin
    #8_000_000;
    $display("image_conv3x3_filter test failed");
    $finish;
  end

  initial begin
    int i;
    for (i = 0; i < 2 * MAX_WIDTH; i++) row_mem[i] = '0;
    for (i = 0; i < 9; i++) win_px[i] = '0;
    rst_ni = 1'b0;
    repeat (8) @(negedge clk_i);
    rst_ni = 1'b1;

    test_sharpen_minimum();
    test_blur_maximum();
    test_mid_image_changes();
    test_size_limits();
    test_backpressure();
    test_random_images();
    wait_idle();

    if (fail_count == 0) begin
      $display("image_conv3x3_filter test passed");
    end else begin
      $display("image_conv3x3_filter test failed");
    end
    $finish;
  end

endmodule

// ===== filelist.f =====
+incdir+sv
sv/icf_pkg.sv
sv/icf_cfg_regs.sv
sv/icf_pos_ctrl.sv
sv/icf_line_store.sv
sv/icf_window_mac.sv
sv/image_conv3x3_filter.sv
sv/icf_checker.sv
tb/image_conv3x3_filter_tb.sv
